>>> rtl/hvd_pkg.sv
// hvd_pkg: shared types and constants for the HMM Viterbi decoder.
// Used by hvd_ctrl, hvd_datapath and hmm_viterbi_decoder. No dependencies.
package hvd_pkg;

    localparam logic [1:0] ACT_LOAD_TRANS = 2'd0;
    localparam logic [1:0] ACT_LOAD_PRIOR = 2'd1;
    localparam logic [1:0] ACT_EMISSION   = 2'd2;
    localparam logic [1:0] ACT_READ       = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_DONE  = 2'd1;
    localparam logic [1:0] ST_PAST_END  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         from_state;
        logic [1:0]         to_state;
        logic [9:0]         step_index;
        logic signed [31:0] log_value;
        logic               final_step;
    } in_item_t;

    typedef struct packed {
        logic [2:0] decoded_state;
        logic [9:0] step_echo;
        logic [1:0] status;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;    // latch input beat
        logic load;       // write transition or prior table
        logic acs_clear;  // start of emission compare
        logic acs_step;   // one predecessor compared
        logic emit_fin;   // write score and back pointer, advance counters
        logic bt_init;    // start backtrack: scan last row
        logic bt_scan;    // compare one entry of last row
        logic bt_first;   // write last decoded entry
        logic bt_req;     // issue back pointer read
        logic bt_wr;      // write decoded entry from read data
        logic rd_req;     // issue decoded path read
        logic rd_out;     // load output register
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] action;
        logic       first_step;
        logic       acs_last;
        logic       step_done;
        logic       go_backtrack;
        logic       scan_last;
        logic       bt_last;
    } stat_t;

endpackage

>>> rtl/hvd_datapath.sv
// hvd_datapath: tables, path score rows, back pointer and decoded path
// memories, the shared add-compare unit and counters. Uses hvd_pkg.
module hvd_datapath #(
    parameter int NUM_STATES  = 4,
    parameter int MAX_STEPS   = 1024,
    parameter int SCORE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hvd_pkg::in_item_t in_item,
    input  logic [2:0]        states_in_use,
    input  hvd_pkg::cmd_t     cmd,
    output hvd_pkg::stat_t    stat,
    output hvd_pkg::out_item_t out_item
);
    import hvd_pkg::*;

    localparam int SB = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int NP = 1 << SB;
    localparam int TB = $clog2(MAX_STEPS);
    localparam int CB = TB + 1;
    localparam int CNTB = $clog2(NUM_STATES + 1);
    localparam int W = SCORE_WIDTH;
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

    function automatic logic signed [W-1:0] log_product(
        input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        logic signed [W:0] s;
        begin
            s = {a[W-1], a} + {b[W-1], b};
            if (a == SMIN || b == SMIN)
                log_product = SMIN;
            else if (s > $signed({SMAX[W-1], SMAX}))
                log_product = SMAX;
            else if (s < $signed({SMIN[W-1], SMIN}))
                log_product = SMIN;
            else
                log_product = s[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] to_score(input logic signed [31:0] raw);
        logic signed [W+31:0] x;
        begin
            x = {{W{raw[31]}}, raw};
            if (raw == 32'sh8000_0000)
                to_score = SMIN;
            else if (x > $signed({{32{1'b0}}, SMAX}))
                to_score = SMAX;
            else if (x < $signed({{32{1'b1}}, SMIN}))
                to_score = SMIN;
            else
                to_score = x[W-1:0];
        end
    endfunction

    in_item_t          it_reg;
    logic signed [W-1:0] trans_reg [NP*NP];
    logic signed [W-1:0] prior_reg [NUM_STATES];
    logic signed [W-1:0] row_reg [2][NUM_STATES];
    logic [SB-1:0]     bp_mem [MAX_STEPS*NP];
    logic [SB-1:0]     path_mem [MAX_STEPS];

    logic [CB-1:0]     step_cnt_reg;
    logic [SB-1:0]     state_cnt_reg;
    logic              path_ready_reg;
    logic [SB-1:0]     i_reg;
    logic signed [W-1:0] best_v_reg;
    logic [SB-1:0]     best_i_reg;
    logic [TB-1:0]     t_reg;
    logic [TB-1:0]     u_reg;
    logic [SB-1:0]     k_reg;
    logic [SB-1:0]     bp_rd_reg;
    logic [SB-1:0]     path_rd_reg;
    out_item_t         out_reg;

    logic [CNTB-1:0] s_act;
    always_comb
    begin
        if (states_in_use == 3'd0)
            s_act = CNTB'(1);
        else if ({29'd0, states_in_use} > 32'(NUM_STATES))
            s_act = CNTB'(NUM_STATES);
        else
            s_act = CNTB'(states_in_use);
    end

    // Effective step and state for the current emission (restart if path done).
    logic [TB-1:0] t_eff;
    logic [SB-1:0] j_eff;
    always_comb
    begin
        if (path_ready_reg || step_cnt_reg == CB'(0))
            t_eff = '0;
        else if (step_cnt_reg >= CB'(MAX_STEPS))
            t_eff = TB'(MAX_STEPS - 1);
        else
            t_eff = step_cnt_reg[TB-1:0];
        j_eff = path_ready_reg ? '0 : state_cnt_reg;
    end

    logic signed [W-1:0] e_score;
    logic signed [W-1:0] cand;
    logic signed [W-1:0] sc;
    logic step_last;
    assign e_score = to_score(it_reg.log_value);
    assign cand = log_product(row_reg[~t_reg[0]][i_reg], trans_reg[{i_reg, j_eff}]);
    assign sc = (t_reg == '0) ? log_product(prior_reg[j_eff], e_score)
                              : log_product(best_v_reg, e_score);
    assign step_last = (CNTB'(j_eff) + CNTB'(1)) >= s_act;

    assign stat.action       = it_reg.action;
    assign stat.first_step   = (t_eff == '0);
    assign stat.acs_last     = (CNTB'(i_reg) + CNTB'(1)) >= s_act;
    assign stat.step_done    = step_last;
    assign stat.go_backtrack = step_last &&
                               (it_reg.final_step || ({1'b0, t_reg} + CB'(1)) >= CB'(MAX_STEPS));
    assign stat.scan_last    = (CNTB'(i_reg) + CNTB'(1)) >= s_act;
    assign stat.bt_last      = (u_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            it_reg <= in_item;
        if (cmd.load)
        begin
            if (it_reg.action == ACT_LOAD_TRANS)
            begin
                if (32'(it_reg.from_state) < NUM_STATES && 32'(it_reg.to_state) < NUM_STATES)
                    trans_reg[{SB'(it_reg.from_state), SB'(it_reg.to_state)}]
                        <= to_score(it_reg.log_value);
            end
            else if (32'(it_reg.to_state) < NUM_STATES)
                prior_reg[SB'(it_reg.to_state)] <= to_score(it_reg.log_value);
        end
        if (cmd.acs_clear)
        begin
            t_reg <= t_eff;
            i_reg <= '0;
            best_i_reg <= '0;
        end
        if (cmd.acs_step)
        begin
            if (i_reg == '0 || cand > best_v_reg)
            begin
                best_v_reg <= cand;
                best_i_reg <= i_reg;
            end
            i_reg <= i_reg + SB'(1);
        end
        if (cmd.emit_fin)
        begin
            row_reg[t_reg[0]][j_eff] <= sc;
            bp_mem[{t_reg, j_eff}] <= (t_reg == '0) ? '0 : best_i_reg;
        end
        if (cmd.bt_init)
        begin
            i_reg <= '0;
            k_reg <= '0;
        end
        if (cmd.bt_scan)
        begin
            if (row_reg[t_reg[0]][i_reg] > row_reg[t_reg[0]][k_reg])
                k_reg <= i_reg;
            i_reg <= i_reg + SB'(1);
        end
        if (cmd.bt_first)
        begin
            path_mem[t_reg] <= k_reg;
            u_reg <= t_reg;
        end
        if (cmd.bt_req)
            bp_rd_reg <= bp_mem[{u_reg, k_reg}];
        if (cmd.bt_wr)
        begin
            path_mem[u_reg - TB'(1)] <= bp_rd_reg;
            k_reg <= bp_rd_reg;
            u_reg <= u_reg - TB'(1);
        end
        if (cmd.rd_req)
            path_rd_reg <= path_mem[it_reg.step_index[TB-1:0]];
        if (cmd.rd_out)
        begin
            out_reg.step_echo <= it_reg.step_index;
            if (!path_ready_reg)
            begin
                out_reg.decoded_state <= '0;
                out_reg.status <= ST_NOT_DONE;
            end
            else if (CB'(it_reg.step_index) >= step_cnt_reg
                     || 32'(it_reg.step_index) >= MAX_STEPS)
            begin
                out_reg.decoded_state <= '0;
                out_reg.status <= ST_PAST_END;
            end
            else
            begin
                out_reg.decoded_state <= 3'(path_rd_reg) + 3'd1;
                out_reg.status <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
            state_cnt_reg <= '0;
            path_ready_reg <= 1'b0;
        end
        else if (cmd.emit_fin)
        begin
            path_ready_reg <= stat.go_backtrack;
            if (step_last)
            begin
                state_cnt_reg <= '0;
                step_cnt_reg <= {1'b0, t_reg} + CB'(1);
            end
            else
            begin
                // t_reg is zero on a restart after a finished path
                state_cnt_reg <= j_eff + SB'(1);
                step_cnt_reg <= {1'b0, t_reg};
            end
        end
    end

    assign out_item = out_reg;

endmodule

>>> rtl/hvd_ctrl.sv
// hvd_ctrl: sequencer for loads, emission compare, backtrack and reads.
// Uses hvd_pkg command and status structs.
module hvd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  hvd_pkg::stat_t stat,
    output hvd_pkg::cmd_t  cmd
);
    import hvd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_ACS   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_BREQ  = 3'd4;
    localparam logic [2:0] S_BWR   = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       first_reg;

    // Output register frees the engine: next beat accepted while result waits;
    // a read then holds in S_RD until the register empties.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_DISP;
            end
            S_DISP:
            begin
                case (stat.action)
                    ACT_LOAD_TRANS, ACT_LOAD_PRIOR:
                    begin
                        cmd.load = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_EMISSION:
                    begin
                        cmd.acs_clear = 1'b1;
                        state_next = stat.first_step ? S_EMIT : S_ACS;
                    end
                    default:
                    begin
                        cmd.rd_req = 1'b1;
                        state_next = S_RD;
                    end
                endcase
            end
            S_ACS:
            begin
                cmd.acs_step = 1'b1;
                if (stat.acs_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_fin = 1'b1;
                if (stat.go_backtrack)
                begin
                    cmd.bt_init = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.bt_scan = 1'b1;
                if (stat.scan_last)
                    state_next = S_BREQ;
            end
            S_BREQ:
            begin
                // First cycle after the scan writes the last step's winner.
                if (first_reg)
                    cmd.bt_first = 1'b1;
                else if (stat.bt_last)
                    state_next = S_IDLE;
                else
                begin
                    cmd.bt_req = 1'b1;
                    state_next = S_BWR;
                end
            end
            S_BWR:
            begin
                cmd.bt_wr = 1'b1;
                state_next = S_BREQ;
            end
            S_RD:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.rd_out = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            first_reg <= (state_reg == S_SCAN) && stat.scan_last;
        end
    end

endmodule

>>> rtl/hmm_viterbi_decoder.sv
// hmm_viterbi_decoder: top level of the log-domain HMM Viterbi decoder.
// Instantiates hvd_ctrl and hvd_datapath; uses hvd_pkg.
//
// Usage:
//   in channel (in_valid/in_ready, in_item): one beat is a command: load a
//   transition entry, load an initial prior, an emission score, or a read.
//   out channel (out_valid/out_ready, out_item): one beat per read command.
//   cfg_we/cfg_data writes states_in_use; write only while idle.
// Sequence:
//   A load is captured, then written to its table. An emission on step 0
//   skips the compare; otherwise the single add-compare unit first walks
//   the S predecessors, S being the active state count. The final emission
//   adds a backtrack: a scan of the last row, then one back pointer memory
//   read per step. A read's result beat is loaded into the output register.
// Reset: counters clear, no decoded path, states_in_use = 4; tables and
//   memories hold garbage until loaded.
// Stall: a waiting result holds in the output register; a following read
//   waits for it to be taken, other commands proceed.
module hmm_viterbi_decoder #(
    parameter int NUM_STATES  = 4,
    parameter int MAX_STEPS   = 1024,
    parameter int SCORE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hvd_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output hvd_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_data
);
    import hvd_pkg::*;

    cmd_t       cmd;
    stat_t      stat;
    logic [2:0] siu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            siu_reg <= 3'd4;
        else if (cfg_we)
            siu_reg <= cfg_data;
    end

    hvd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hvd_datapath #(
        .NUM_STATES  (NUM_STATES),
        .MAX_STEPS   (MAX_STEPS),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_item       (in_item),
        .states_in_use (siu_reg),
        .cmd           (cmd),
        .stat          (stat),
        .out_item      (out_item)
    );

endmodule
